>>> design/baro_pkg.sv
// Shared constants, types and rounding helper for the barometer compensation core.
package baro_pkg;

  localparam int RawW   = 24;
  localparam int CalW   = 56;
  localparam int CfgIdxW = 2;
  localparam int TempW  = 23;
  localparam int PresW  = 32;

  // Register indexes of the calibration words.
  localparam logic [CfgIdxW-1:0] CFG_CAL_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAL_MID  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAL_HIGH = 2'd2;

  // Reciprocal of 15 scaled by 2^28, exact for 24-bit dividends.
  localparam logic [24:0] RECIP15 = 25'd17895698;
  localparam int RecipShift = 28;

  localparam logic signed [63:0] TEMP_MAX = 64'sd4194303;
  localparam logic signed [63:0] TEMP_MIN = -64'sd4194304;
  localparam logic signed [63:0] PRES_MAX = 64'sd2147483647;
  localparam logic signed [63:0] PRES_MIN = -64'sd2147483648;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [63:0] wide_t;
  typedef logic signed [47:0] cprod_t;

  // Divide by 2^n, rounding to nearest with ties away from zero.
  function automatic wide_t rnd_shift(input wide_t x, input int n);
    wide_t half;
    half = (64'sd1 <<< (n - 1)) - (x < 0 ? 64'sd1 : 64'sd0);
    return (x + half) >>> n;
  endfunction

  // Fraction part of the scaling: round((rem * 2048) / 15) for rem below 15.
  function automatic logic [10:0] frac15(input logic [3:0] rem);
    logic [10:0] v;
    case (rem)
      4'd0:    v = 11'd0;
      4'd1:    v = 11'd137;
      4'd2:    v = 11'd273;
      4'd3:    v = 11'd410;
      4'd4:    v = 11'd546;
      4'd5:    v = 11'd683;
      4'd6:    v = 11'd819;
      4'd7:    v = 11'd956;
      4'd8:    v = 11'd1092;
      4'd9:    v = 11'd1229;
      4'd10:   v = 11'd1365;
      4'd11:   v = 11'd1502;
      4'd12:   v = 11'd1638;
      4'd13:   v = 11'd1775;
      4'd14:   v = 11'd1911;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/baro_pressure_temp_compensation_core.sv
// Barometer pressure and temperature compensation pipeline, top level.
//
// Input channel in_*: one beat carries raw_pressure in in_tdata[23:0] and
// raw_temperature in in_tdata[47:24], both 24-bit two's complement words.
// Output channel out_*: one beat per input beat, temperature_q10 in
// out_tdata[22:0], pressure_q6 in out_tdata[54:23], and the saturated flag
// in out_tuser.
// Configuration channel cfg_*: writes calibration word cfg_index (0 low,
// 1 mid, 2 high) with cfg_data; index 3 is ignored. cfg_ready is always high.
// Write calibration only while no beats are in flight.
// The pipeline has 13 register stages. Throughput is one beat per cycle while
// the receiver does not stall; the depth is set by the chain of three
// dependent 32x32 power multiplies, each followed by a rounding stage.
// Reset clears all stage valid bits and the calibration words to zero.
// When the receiver stalls, the whole pipeline freezes and in_tready drops,
// so no beat is lost or repeated; the output beat is held stable.
module baro_pressure_temp_compensation_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [47:0]                     in_tdata,   // raw_pressure, raw_temperature
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [55:0]                     out_tdata,  // temperature_q10, pressure_q6, pad
  output logic                            out_tuser,  // saturated
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [baro_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [baro_pkg::CalW-1:0]       cfg_data
);
  import baro_pkg::*;

  localparam int NStage = 13;

  // Calibration words.
  logic [CalW-1:0] cal_low_r, cal_mid_r, cal_high_r;
  logic [3*CalW-1:0] cal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_r  <= '0;
      cal_mid_r  <= '0;
      cal_high_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAL_LOW:  cal_low_r  <= cfg_data;
        CFG_CAL_MID:  cal_mid_r  <= cfg_data;
        CFG_CAL_HIGH: cal_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Coefficient fields, big-endian from byte 0.
  logic signed [11:0] c0, c1, c31, c40;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  assign cal = {cal_low_r, cal_mid_r, cal_high_r};
  assign c0  = cal[167:156];
  assign c1  = cal[155:144];
  assign c00 = cal[143:124];
  assign c10 = cal[123:104];
  assign c01 = cal[103:88];
  assign c11 = cal[87:72];
  assign c20 = cal[71:56];
  assign c21 = cal[55:40];
  assign c30 = cal[39:24];
  assign c31 = cal[23:12];
  assign c40 = cal[11:0];

  // Global advance: the pipeline moves when the output slot is free or taken.
  logic adv;
  logic [NStage:1] vld_r;

  assign adv       = !vld_r[NStage] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NStage-1:1], in_tvalid};
    end
  end

  // Stages 1 and 2: scaling of both readings.
  q30_t p, t;

  baro_scale u_scale_p (
    .clk   (clk),
    .en    (adv),
    .raw   (in_tdata[23:0]),
    .value (p)
  );

  baro_scale u_scale_t (
    .clk   (clk),
    .en    (adv),
    .raw   (in_tdata[47:24]),
    .value (t)
  );

  // Stage registers. The c10 term needs more than 48 bits.
  q30_t   p3s_r, p4s_r, p5s_r, p6s_r;
  q30_t   t3_r, t4_r, t5_r, t6_r, t7_r, t8_r, t9_r;
  wide_t  pp_r, pp3_r, pp4_r, xp_r;
  cprod_t tsum_r;
  wide_t  c10p3_r, c10p4_r, c10p5_r, c10p6_r, c10p7_r, c10p8_r, c10p9_r;
  cprod_t c11p3_r, c11p4_r, c11p5_r, c11p6_r, c11p7_r;
  q30_t   p2_r, p3_r, p4_r;
  cprod_t c20p5_r, c20p6_r, c20p7_r, c20p8_r, c20p9_r;
  cprod_t c21p5_r, c21p6_r, c21p7_r;
  cprod_t c30p7_r, c30p8_r, c30p9_r;
  cprod_t c31p7_r;
  cprod_t c40p9_r;
  cprod_t s_r;
  q30_t   s14_r;
  logic signed [53:0] part_r, part11_r, acc_r;
  wide_t  x_r;
  logic signed [23:0] temp4_r, temp5_r, temp6_r, temp7_r, temp8_r, temp9_r;
  logic signed [23:0] temp10_r, temp11_r, temp12_r;
  logic [TempW-1:0] out_temp_r;
  logic [PresW-1:0] out_pres_r;
  logic             out_sat_r;

  // Rounded intermediates.
  wide_t p2_w, p3_w, p4_w, temp_w, s14_w, x_w, pres_w, tclip_w;
  wide_t tsum_w, s_w, part_w, acc_w;

  assign p2_w   = rnd_shift(pp_r, 30);
  assign temp_w = rnd_shift(wide_t'(tsum_r), 20);
  assign p3_w   = rnd_shift(pp3_r, 30);
  assign p4_w   = rnd_shift(pp4_r, 30);
  assign s14_w  = rnd_shift(wide_t'(s_r), 16);
  assign x_w    = rnd_shift(xp_r, 14);
  assign pres_w = rnd_shift(wide_t'(acc_r), 24);
  assign tclip_w = wide_t'(temp12_r);

  // Sums, formed in the wide domain and narrowed to their known ranges.
  assign tsum_w = (wide_t'(c0) <<< 29) + wide_t'(c1) * wide_t'(t);
  assign s_w    = (wide_t'(c01) <<< 30) + wide_t'(c11p7_r) + wide_t'(c21p7_r)
                + wide_t'(c31p7_r);
  assign part_w = (wide_t'(c00) <<< 30) + wide_t'(c10p9_r) + wide_t'(c20p9_r)
                + wide_t'(c30p9_r) + wide_t'(c40p9_r);
  assign acc_w  = wide_t'(part11_r) + x_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 3: first square, temperature sum, linear pressure terms.
      pp_r    <= wide_t'(p) * wide_t'(p);
      tsum_r  <= tsum_w[47:0];
      c10p3_r <= wide_t'(c10) * wide_t'(p);
      c11p3_r <= cprod_t'(c11) * cprod_t'(p);
      p3s_r   <= p;
      t3_r    <= t;
      // Stage 4: round the square and the temperature.
      p2_r    <= p2_w[31:0];
      temp4_r <= temp_w[23:0];
      c10p4_r <= c10p3_r;
      c11p4_r <= c11p3_r;
      p4s_r   <= p3s_r;
      t4_r    <= t3_r;
      // Stage 5: cube product and square terms.
      pp3_r   <= wide_t'(p2_r) * wide_t'(p4s_r);
      c20p5_r <= cprod_t'(c20) * cprod_t'(p2_r);
      c21p5_r <= cprod_t'(c21) * cprod_t'(p2_r);
      c10p5_r <= c10p4_r;
      c11p5_r <= c11p4_r;
      p5s_r   <= p4s_r;
      t5_r    <= t4_r;
      temp5_r <= temp4_r;
      // Stage 6: round the cube.
      p3_r    <= p3_w[31:0];
      c20p6_r <= c20p5_r;
      c21p6_r <= c21p5_r;
      c10p6_r <= c10p5_r;
      c11p6_r <= c11p5_r;
      p6s_r   <= p5s_r;
      t6_r    <= t5_r;
      temp6_r <= temp5_r;
      // Stage 7: fourth power product and cube terms.
      pp4_r   <= wide_t'(p3_r) * wide_t'(p6s_r);
      c30p7_r <= cprod_t'(c30) * cprod_t'(p3_r);
      c31p7_r <= cprod_t'(c31) * cprod_t'(p3_r);
      c20p7_r <= c20p6_r;
      c21p7_r <= c21p6_r;
      c10p7_r <= c10p6_r;
      c11p7_r <= c11p6_r;
      t7_r    <= t6_r;
      temp7_r <= temp6_r;
      // Stage 8: round the fourth power and form the cross sum.
      p4_r    <= p4_w[31:0];
      s_r     <= s_w[47:0];
      c30p8_r <= c30p7_r;
      c20p8_r <= c20p7_r;
      c10p8_r <= c10p7_r;
      t8_r    <= t7_r;
      temp8_r <= temp7_r;
      // Stage 9: fourth power term and rounded cross sum.
      c40p9_r <= cprod_t'(c40) * cprod_t'(p4_r);
      s14_r   <= s14_w[31:0];
      c30p9_r <= c30p8_r;
      c20p9_r <= c20p8_r;
      c10p9_r <= c10p8_r;
      t9_r    <= t8_r;
      temp9_r <= temp8_r;
      // Stage 10: temperature cross product and polynomial sum.
      xp_r     <= wide_t'(s14_r) * wide_t'(t9_r);
      part_r   <= part_w[53:0];
      temp10_r <= temp9_r;
      // Stage 11: round the cross term.
      x_r      <= x_w;
      part11_r <= part_r;
      temp11_r <= temp10_r;
      // Stage 12: full pressure accumulator.
      acc_r    <= acc_w[53:0];
      temp12_r <= temp11_r;
      // Stage 13: final rounding and clipping into the output register.
      if (tclip_w > TEMP_MAX) begin
        out_temp_r <= TEMP_MAX[TempW-1:0];
      end else if (tclip_w < TEMP_MIN) begin
        out_temp_r <= TEMP_MIN[TempW-1:0];
      end else begin
        out_temp_r <= tclip_w[TempW-1:0];
      end
      if (pres_w > PRES_MAX) begin
        out_pres_r <= PRES_MAX[PresW-1:0];
      end else if (pres_w < PRES_MIN) begin
        out_pres_r <= PRES_MIN[PresW-1:0];
      end else begin
        out_pres_r <= pres_w[PresW-1:0];
      end
      out_sat_r <= (tclip_w > TEMP_MAX) || (tclip_w < TEMP_MIN)
                || (pres_w > PRES_MAX) || (pres_w < PRES_MIN);
    end
  end

  assign out_tvalid = vld_r[NStage];
  assign out_tdata  = {1'b0, out_pres_r, out_temp_r};
  assign out_tuser  = out_sat_r;

endmodule

>>> design/baro_scale.sv
// Two-stage scaling of a raw 24-bit reading into signed Q2.30.
module baro_scale (
  input  logic                        clk,
  input  logic                        en,
  input  logic [baro_pkg::RawW-1:0]   raw,
  output baro_pkg::q30_t              value
);
  import baro_pkg::*;

  logic              neg_r;
  logic [RawW-1:0]   mag_r;
  logic [48:0]       prod_r;
  q30_t              value_r;

  logic [RawW-1:0]   mag_nxt;
  logic [20:0]       quo;
  logic [RawW-1:0]   rem;
  logic [31:0]       q;
  q30_t              value_nxt;

  // Stage one: magnitude and reciprocal product.
  assign mag_nxt = raw[RawW-1] ? (~raw + 1'b1) : raw;

  // Stage two: quotient, remainder correction and sign.
  assign quo       = prod_r[RecipShift +: 21];
  assign rem       = mag_r - ({3'd0, quo} * 24'd15);
  assign q         = {quo, 11'd0} + {21'd0, frac15(rem[3:0])};
  assign value_nxt = neg_r ? -q30_t'(q) : q30_t'(q);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r   <= raw[RawW-1];
      mag_r   <= mag_nxt;
      prod_r  <= {25'd0, mag_nxt} * {24'd0, RECIP15};
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

>>> design/baro_chk.sv
// Port-level checker for the barometer compensation core, with its bind.
module baro_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);

  // A stalled output beat holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The pipeline accepts exactly when its output slot can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output slot");

  // The saturation flag is only raised with a result pinned at a limit.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[22:0] == 23'h3FFFFF) || (out_tdata[22:0] == 23'h400000) ||
      (out_tdata[54:23] == 32'h7FFFFFFF) || (out_tdata[54:23] == 32'h80000000))
    else $error("saturation flag without a clipped result");

endmodule

bind baro_pressure_temp_compensation_core baro_chk u_baro_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
